/* design/expression_lexer_implicit_multiply_defines.svh */
// assertion macros for the checker file
// no dependencies
`ifndef EXPRESSION_LEXER_IMPLICIT_MULTIPLY_DEFINES_SVH
`define EXPRESSION_LEXER_IMPLICIT_MULTIPLY_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ELIM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("elim check failed");

// next-cycle implication, checked outside reset
`define ELIM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("elim check failed");

`endif

/* design/elim_pkg.sv */
// types, character codes and helpers for the expression lexer
// no dependencies
package elim_pkg;

    localparam int POS_WIDTH = 16;

    typedef logic [POS_WIDTH-1:0] t_pos;
    localparam t_pos POS_MAX = '1;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_NUM  = 2'd1,
        MODE_NAME = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        KIND_TOKEN    = 2'd0,
        KIND_OP       = 2'd1,
        KIND_DECERR   = 2'd2,
        KIND_FINISHED = 2'd3
    } t_kind;

    typedef struct packed {
        t_mode mode;
        logic  seen_decimal;
        t_pos  position;
        t_pos  cur_start;
        t_pos  cur_length;
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [7:0]  op_char;
        logic        last;
    } t_result;

    // results of one character, handed to the result buffer
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_push;

    // position or length masked to the 16-bit output field
    function automatic logic [15:0] to16(t_pos p);
        logic [POS_WIDTH+15:0] ext;
        ext = {16'b0, p};
        return ext[15:0];
    endfunction

endpackage

/* design/expression_lexer_implicit_multiply.sv */
// top level of the expression lexer with implicit multiply
// depends on elim_pkg, elim_step and elim_rbuf
//
//  channel | direction | tdata (low bit up)                 | tuser | tlast
//  --------+-----------+------------------------------------+-------+------------
//  s       | in        | ch[7:0]                            | -     | -
//  m       | out       | token_start, token_length, op_char | kind  | last result
//
// an accepted character waits in the input register until the result buffer
// has room for two results, then the step logic updates the lexer state and
// writes zero, one or two results into the result buffer, which drives the port
// one character per cycle is taken while results drain at one per cycle and no
// character gives two results; such a character uses the result port twice
// stalls on the result side back up through the buffer to o_s_tready
// synchronous active-low reset clears lexer state, buffer fill and input valid
module expression_lexer_implicit_multiply (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // ch[7:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // token_start[15:0], token_length[31:16], op_char[39:32]
    output logic [1:0]  o_m_tuser,   // kind[1:0]
    output logic        o_m_tlast
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_ch;
    logic       in_fire;
    logic       proc;
    logic       room;

    // lexer state
    elim_pkg::t_state r_state;
    elim_pkg::t_state n_state;
    elim_pkg::t_push  push;
    elim_pkg::t_result head;

    // character is processed once the buffer can take two results
    assign proc       = r_in_valid && room;
    assign o_s_tready = !r_in_valid || proc;
    assign in_fire    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_ch <= i_s_tdata;
        end
    end

    elim_step u_step (
        .i_state (r_state),
        .i_ch    (r_in_ch),
        .o_state (n_state),
        .o_push  (push)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode         <= elim_pkg::MODE_NONE;
            r_state.seen_decimal <= 1'b0;
            r_state.position     <= '0;
            r_state.cur_start    <= '0;
            r_state.cur_length   <= '0;
        end else if (proc) begin
            r_state <= n_state;
        end
    end

    elim_rbuf u_rbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_en   (proc),
        .i_push      (push),
        .i_pop_ready (i_m_tready),
        .o_room      (room),
        .o_valid     (o_m_tvalid),
        .o_head      (head)
    );

    // result fields onto the bus
    assign o_m_tdata = {head.op_char, head.token_length, head.token_start};
    assign o_m_tuser = head.kind;
    assign o_m_tlast = head.last;

endmodule

/* design/elim_step.sv */
// next-state and result logic for one character of the lexer
// depends on elim_pkg
module elim_step (
    input  elim_pkg::t_state i_state,
    input  logic [7:0]       i_ch,
    output elim_pkg::t_state o_state,
    output elim_pkg::t_push  o_push
);

    logic             do_flush;
    logic             do_append;
    logic             tok_v;
    logic             extra_v;
    elim_pkg::t_kind  extra_kind;
    logic [7:0]       extra_op;
    elim_pkg::t_result tok_res;
    elim_pkg::t_result extra_res;
    elim_pkg::t_pos   base_start;
    elim_pkg::t_pos   base_len;
    elim_pkg::t_state nxt;
    logic             name_like;

    always_comb begin
        name_like = (i_state.mode != elim_pkg::MODE_NONE) &&
                    (i_state.mode != elim_pkg::MODE_NUM);
        nxt        = i_state;
        do_flush   = 1'b0;
        do_append  = 1'b0;
        extra_v    = 1'b0;
        extra_kind = elim_pkg::KIND_OP;
        extra_op   = 8'd0;

        case (i_ch) inside
            elim_pkg::CH_NUL: begin
                do_flush   = 1'b1;
                extra_v    = 1'b1;
                extra_kind = elim_pkg::KIND_FINISHED;
            end
            elim_pkg::CH_SPACE: begin
                do_flush = 1'b1;
                nxt.mode = elim_pkg::MODE_NONE;
            end
            elim_pkg::CH_LPAREN, elim_pkg::CH_RPAREN, elim_pkg::CH_COMMA,
            elim_pkg::CH_PLUS, elim_pkg::CH_MINUS, elim_pkg::CH_STAR,
            elim_pkg::CH_SLASH, elim_pkg::CH_CARET: begin
                do_flush = 1'b1;
                extra_v  = 1'b1;
                extra_op = i_ch;
                nxt.mode = elim_pkg::MODE_NONE;
            end
            [elim_pkg::CH_ZERO:elim_pkg::CH_NINE], elim_pkg::CH_DOT: begin
                do_append = 1'b1;
                if (name_like) begin
                    // digit or decimal point after a name: implicit multiply
                    do_flush         = 1'b1;
                    extra_v          = 1'b1;
                    extra_op         = elim_pkg::CH_STAR;
                    nxt.mode         = elim_pkg::MODE_NUM;
                    nxt.seen_decimal = (i_ch == elim_pkg::CH_DOT);
                end else begin
                    nxt.mode = elim_pkg::MODE_NUM;
                    if (i_state.mode == elim_pkg::MODE_NONE) begin
                        nxt.seen_decimal = 1'b0;
                    end
                    if (i_ch == elim_pkg::CH_DOT) begin
                        if ((i_state.mode == elim_pkg::MODE_NUM) && i_state.seen_decimal) begin
                            extra_v    = 1'b1;
                            extra_kind = elim_pkg::KIND_DECERR;
                        end
                        nxt.seen_decimal = 1'b1;
                    end
                end
            end
            default: begin
                do_append = 1'b1;
                if (i_state.mode == elim_pkg::MODE_NUM) begin
                    // any other character after a number: implicit multiply
                    do_flush = 1'b1;
                    extra_v  = 1'b1;
                    extra_op = elim_pkg::CH_STAR;
                end
                nxt.mode = elim_pkg::MODE_NAME;
            end
        endcase

        tok_v = do_flush && (i_state.cur_length != '0);

        base_start = do_flush ? '0 : i_state.cur_start;
        base_len   = do_flush ? '0 : i_state.cur_length;
        nxt.cur_start  = base_start;
        nxt.cur_length = base_len;
        if (do_append) begin
            if (base_len == '0) begin
                nxt.cur_start = i_state.position;
            end
            if (base_len != elim_pkg::POS_MAX) begin
                nxt.cur_length = base_len + 1'b1;
            end
        end

        if (i_state.position != elim_pkg::POS_MAX) begin
            nxt.position = i_state.position + 1'b1;
        end

        // end of text returns everything to reset values
        if (i_ch == elim_pkg::CH_NUL) begin
            nxt.mode         = elim_pkg::MODE_NONE;
            nxt.seen_decimal = 1'b0;
            nxt.position     = '0;
            nxt.cur_start    = '0;
            nxt.cur_length   = '0;
        end

        tok_res.kind         = elim_pkg::KIND_TOKEN;
        tok_res.token_start  = elim_pkg::to16(i_state.cur_start);
        tok_res.token_length = elim_pkg::to16(i_state.cur_length);
        tok_res.op_char      = 8'd0;
        tok_res.last         = !extra_v;

        extra_res.kind         = extra_kind;
        extra_res.token_start  = 16'd0;
        extra_res.token_length = 16'd0;
        extra_res.op_char      = (extra_kind == elim_pkg::KIND_OP) ? extra_op : 8'd0;
        extra_res.last         = 1'b1;

        o_push.cnt  = {1'b0, tok_v} + {1'b0, extra_v};
        o_push.res0 = tok_v ? tok_res : extra_res;
        o_push.res1 = extra_res;
        o_state     = nxt;
    end

endmodule

/* design/elim_rbuf.sv */
// three-entry result buffer: takes up to two results, gives one per cycle while the reader is ready
// depends on elim_pkg
module elim_rbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_en,
    input  elim_pkg::t_push   i_push,
    input  logic              i_pop_ready,
    output logic              o_room,
    output logic              o_valid,
    output elim_pkg::t_result o_head
);

    elim_pkg::t_result r_ent [3];
    elim_pkg::t_result n_ent [3];
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       pop;
    logic [1:0] base;
    logic [1:0] push_cnt;

    always_comb begin
        pop      = (r_count != 2'd0) && i_pop_ready;
        base     = r_count - {1'b0, pop};
        o_room   = (base <= 2'd1);
        push_cnt = i_push_en ? i_push.cnt : 2'd0;
        n_ent[0] = pop ? r_ent[1] : r_ent[0];
        n_ent[1] = pop ? r_ent[2] : r_ent[1];
        n_ent[2] = r_ent[2];
        for (int i = 0; i < 3; i++) begin
            if ((push_cnt != 2'd0) && (base == 2'(i))) begin
                n_ent[i] = i_push.res0;
            end
            if ((push_cnt == 2'd2) && (base + 2'd1 == 2'(i))) begin
                n_ent[i] = i_push.res1;
            end
        end
        n_count = base + push_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_ent[0];

endmodule

/* design/elim_checker.sv */
// port-level checks on the lexer result stream, bound to the top level
// depends on elim_pkg and the macro header
`include "expression_lexer_implicit_multiply_defines.svh"

module elim_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] i_m_tdata,
    input logic [1:0]  i_m_tuser,
    input logic        i_m_tlast
);

    // a stalled request keeps its payload
    `ELIM_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser) && $stable(i_m_tlast))

    // only token spans carry start and length
    `ELIM_ASSERT_NOW(a_span_zero, i_clk, i_rst_n, i_m_tvalid && (i_m_tuser != elim_pkg::KIND_TOKEN), i_m_tdata[31:0] == 32'd0)

    // only operators carry a character
    `ELIM_ASSERT_NOW(a_op_zero, i_clk, i_rst_n, i_m_tvalid && (i_m_tuser != elim_pkg::KIND_OP), i_m_tdata[39:32] == 8'd0)

    // a token span is never empty
    `ELIM_ASSERT_NOW(a_tok_len, i_clk, i_rst_n, i_m_tvalid && (i_m_tuser == elim_pkg::KIND_TOKEN), i_m_tdata[31:16] != 16'd0)

    // finished always closes the results of its character
    `ELIM_ASSERT_NOW(a_fin_last, i_clk, i_rst_n, i_m_tvalid && (i_m_tuser == elim_pkg::KIND_FINISHED), i_m_tlast)

endmodule

bind expression_lexer_implicit_multiply elim_checker u_elim_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser),
    .i_m_tlast  (o_m_tlast)
);
